// ===== src/ccpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpp_pkg
// Types, codes and tag decode shared by the constant pool parser modules.
// ----------------------------------------------------------------------------
package ccpp_pkg;

    // result kinds
    localparam logic [1:0] KIND_ENTRY    = 2'd0;
    localparam logic [1:0] KIND_DATA     = 2'd1;
    localparam logic [1:0] KIND_UNUSABLE = 2'd2;
    localparam logic [1:0] KIND_BAD_TAG  = 2'd3;

    // constant pool tags
    localparam logic [7:0] TAG_UTF8           = 8'd1;
    localparam logic [7:0] TAG_INTEGER        = 8'd3;
    localparam logic [7:0] TAG_FLOAT          = 8'd4;
    localparam logic [7:0] TAG_LONG           = 8'd5;
    localparam logic [7:0] TAG_DOUBLE         = 8'd6;
    localparam logic [7:0] TAG_CLASS          = 8'd7;
    localparam logic [7:0] TAG_STRING         = 8'd8;
    localparam logic [7:0] TAG_FIELDREF       = 8'd9;
    localparam logic [7:0] TAG_METHODREF      = 8'd10;
    localparam logic [7:0] TAG_IMETHODREF     = 8'd11;
    localparam logic [7:0] TAG_NAME_AND_TYPE  = 8'd12;
    localparam logic [7:0] TAG_METHOD_HANDLE  = 8'd15;
    localparam logic [7:0] TAG_METHOD_TYPE    = 8'd16;
    localparam logic [7:0] TAG_INVOKE_DYNAMIC = 8'd18;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_OPER,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] slot_index;
        logic [7:0]  tag;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic [7:0]  data_byte;
        logic        last_of_run;
        logic        pool_done;
    } t_result;

    // operand byte count of a tag, zero for an unknown tag
    function automatic logic [3:0] operand_bytes(input logic [7:0] t);
        logic [3:0] n;
        case (t)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: n = 4'd2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IMETHODREF, TAG_NAME_AND_TYPE, TAG_INVOKE_DYNAMIC: n = 4'd4;
            TAG_LONG, TAG_DOUBLE: n = 4'd8;
            TAG_METHOD_HANDLE: n = 4'd3;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== src/ccpp_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpp_out_queue
// Two-entry result queue; takes up to two results per input item.
// ----------------------------------------------------------------------------
module ccpp_out_queue import ccpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_space,
    output logic       o_valid,
    output t_result    o_head,
    input  logic       i_ready
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    logic [1:0] left_cnt;
    t_result    r_q0;
    t_result    r_q1;
    t_result    n_q0;
    t_result    n_q1;
    logic       pop;

    assign pop     = (r_count != 2'd0) && i_ready;
    // room for two results once the head leaves
    assign o_space = (r_count == 2'd0) || ((r_count == 2'd1) && i_ready);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_q0;

    always_comb begin
        n_q0     = r_q0;
        n_q1     = r_q1;
        left_cnt = r_count - {1'b0, pop};
        if (pop) begin
            n_q0 = r_q1;
        end
        if (i_push_cnt != 2'd0) begin
            if (left_cnt == 2'd0) begin
                n_q0 = i_res0;
            end else begin
                n_q1 = i_res0;
            end
        end
        if (i_push_cnt == 2'd2) begin
            n_q1 = i_res1;
        end
        n_count = left_cnt + i_push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

// ===== src/class_constant_pool_parser.sv =====
// A result is offered in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the result queue has space; a byte that causes
// two results (long or double entry) fills the two-entry queue, which holds off input.
// Reset (synchronous, active low): parse restarts at slot 1, count reads 1,
// the halt is cleared and the result queue is emptied.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_constant_pool_parser
// Byte-serial class file constant pool parser: records entries, UTF8 bytes, unusable slots.
// ----------------------------------------------------------------------------
module class_constant_pool_parser import ccpp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: constant pool count
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // byte_in
    input  logic [0:0]  i_s_tuser,   // begin_req
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // slot_index, tag, first_value, second_value, data_byte
    output logic [2:0]  o_m_tuser,   // kind[1:0], pool_done
    output logic        o_m_tlast    // last_of_run
);

    logic [15:0] r_entry_count;
    t_phase      r_phase,  n_phase;
    logic [7:0]  r_tag,    n_tag;
    logic [15:0] r_left,   n_left;
    logic [63:0] r_shift,  n_shift;
    logic [15:0] r_slot,   n_slot;
    logic        r_halted, n_halted;

    t_phase      e_phase;
    logic [7:0]  e_tag;
    logic [15:0] e_left;
    logic [63:0] e_shift;
    logic [15:0] e_slot;
    logic        e_halted;

    logic        s_acc;
    logic [7:0]  in_byte;
    logic [3:0]  oper_n;
    logic [15:0] left_dec;
    logic [63:0] shift_new;
    logic [15:0] slot_adv1;
    logic [15:0] slot_adv2;
    logic        room;
    logic [1:0]  push_cnt;
    t_result     res0;
    t_result     res1;
    t_result     head;
    logic        space;

    function automatic logic [15:0] f_advance(input logic [15:0] slot,
                                              input logic [15:0] cnt,
                                              input logic [1:0]  step);
        logic [16:0] s;
        s = {1'b0, slot} + {15'd0, step};
        if ((s > {1'b0, cnt}) && (cnt > slot)) begin
            s = {1'b0, cnt};
        end
        return s[15:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = space;
    assign s_acc       = i_s_tvalid && space;
    assign in_byte     = i_s_tdata;

    // begin_req restarts the parse ahead of its own byte
    always_comb begin
        if (i_s_tuser[0]) begin
            e_phase  = PH_TAG;
            e_tag    = 8'd0;
            e_left   = 16'd0;
            e_shift  = 64'd0;
            e_slot   = 16'd1;
            e_halted = 1'b0;
        end else begin
            e_phase  = r_phase;
            e_tag    = r_tag;
            e_left   = r_left;
            e_shift  = r_shift;
            e_slot   = r_slot;
            e_halted = r_halted;
        end
    end

    assign oper_n    = operand_bytes(in_byte);
    assign left_dec  = e_left - 16'd1;
    assign shift_new = {e_shift[55:0], in_byte};
    assign slot_adv1 = f_advance(e_slot, r_entry_count, 2'd1);
    assign slot_adv2 = f_advance(e_slot, r_entry_count, 2'd2);
    assign room      = ({1'b0, e_slot} + 17'd1) < {1'b0, r_entry_count};

    always_comb begin
        n_phase  = r_phase;
        n_tag    = r_tag;
        n_left   = r_left;
        n_shift  = r_shift;
        n_slot   = r_slot;
        n_halted = r_halted;
        push_cnt = 2'd0;
        res0     = '0;
        res1     = '0;
        if (s_acc) begin
            n_phase  = e_phase;
            n_tag    = e_tag;
            n_left   = e_left;
            n_shift  = e_shift;
            n_slot   = e_slot;
            n_halted = e_halted;
            res0.slot_index  = e_slot;
            res0.tag         = e_tag;
            res0.last_of_run = 1'b1;
            if (!e_halted) begin
                case (e_phase)
                    PH_TAG: begin
                        if (e_slot < r_entry_count) begin
                            n_tag = in_byte;
                            if (oper_n == 4'd0) begin
                                n_halted  = 1'b1;
                                res0.kind = KIND_BAD_TAG;
                                res0.tag  = in_byte;
                                push_cnt  = 2'd1;
                            end else begin
                                n_phase = PH_OPER;
                                n_left  = {12'd0, oper_n};
                                n_shift = 64'd0;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_left         = left_dec;
                        res0.kind      = KIND_DATA;
                        res0.data_byte = in_byte;
                        push_cnt       = 2'd1;
                        if (left_dec == 16'd0) begin
                            n_slot         = slot_adv1;
                            n_phase        = PH_TAG;
                            res0.pool_done = (slot_adv1 >= r_entry_count);
                        end
                    end
                    PH_OPER: begin
                        n_shift = shift_new;
                        n_left  = left_dec;
                        if (left_dec == 16'd0) begin
                            n_phase        = PH_TAG;
                            n_shift        = 64'd0;
                            res0.kind      = KIND_ENTRY;
                            push_cnt       = 2'd1;
                            n_slot         = slot_adv1;
                            res0.pool_done = (slot_adv1 >= r_entry_count);
                            case (e_tag)
                                TAG_UTF8: begin
                                    res0.first_value = {16'd0, shift_new[15:0]};
                                    if (shift_new[15:0] != 16'd0) begin
                                        // string bytes follow, slot stays open
                                        n_phase        = PH_DATA;
                                        n_left         = shift_new[15:0];
                                        n_slot         = e_slot;
                                        res0.pool_done = 1'b0;
                                    end
                                end
                                TAG_LONG, TAG_DOUBLE: begin
                                    res0.first_value  = shift_new[63:32];
                                    res0.second_value = shift_new[31:0];
                                    if (room) begin
                                        n_slot            = slot_adv2;
                                        res0.pool_done    = 1'b0;
                                        res0.last_of_run  = 1'b0;
                                        res1.kind         = KIND_UNUSABLE;
                                        res1.slot_index   = e_slot + 16'd1;
                                        res1.last_of_run  = 1'b1;
                                        res1.pool_done    = (slot_adv2 >= r_entry_count);
                                        push_cnt          = 2'd2;
                                    end
                                end
                                TAG_METHOD_HANDLE: begin
                                    res0.first_value  = {24'd0, shift_new[23:16]};
                                    res0.second_value = {16'd0, shift_new[15:0]};
                                end
                                TAG_INTEGER, TAG_FLOAT: begin
                                    res0.first_value = shift_new[31:0];
                                end
                                TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: begin
                                    res0.first_value = {16'd0, shift_new[15:0]};
                                end
                                default: begin
                                    // two u2 indexes
                                    res0.first_value  = {16'd0, shift_new[31:16]};
                                    res0.second_value = {16'd0, shift_new[15:0]};
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= 16'd1;
            r_phase       <= PH_TAG;
            r_tag         <= 8'd0;
            r_left        <= 16'd0;
            r_shift       <= 64'd0;
            r_slot        <= 16'd1;
            r_halted      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_entry_count <= i_cfg_data;
            end
            r_phase  <= n_phase;
            r_tag    <= n_tag;
            r_left   <= n_left;
            r_shift  <= n_shift;
            r_slot   <= n_slot;
            r_halted <= n_halted;
        end
    end

    ccpp_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_space    (space),
        .o_valid    (o_m_tvalid),
        .o_head     (head),
        .i_ready    (i_m_tready)
    );

    assign o_m_tdata = {head.data_byte, head.second_value, head.first_value,
                        head.tag, head.slot_index};
    assign o_m_tuser = {head.pool_done, head.kind};
    assign o_m_tlast = head.last_of_run;

endmodule
